[hw/rtl/sqvb_pkg.sv]
// Shared types, constants and the CORDIC arc table for the sprite quad batcher.
// No dependencies; every other file of the block imports this package.
package sqvb_pkg;

	localparam int BATCH_QUAD_CAP  = 16384;
	localparam int SLOT_TABLE_SIZE = 32;
	localparam int QCNT_W        = $clog2(BATCH_QUAD_CAP + 1);
	localparam int USED_W        = $clog2(SLOT_TABLE_SIZE + 1);
	localparam int SIDX_W        = $clog2(SLOT_TABLE_SIZE);
	localparam int SLOT_W        = 5;
	localparam int INDEX_W       = 17;
	localparam int QDEPTH        = 2;
	localparam int CORDIC_STEPS  = 15;
	localparam int STEP_W        = $clog2(CORDIC_STEPS);
	localparam int CORDIC_GAIN   = 39797;
	localparam int CS_W          = 19;
	localparam int Z_W           = 16;
	localparam int PROD_W        = CS_W + 32;
	localparam int SUM_W         = PROD_W + 1;
	localparam int OFS_W         = SUM_W + 1;
	localparam int ROUND_HALF    = 65536;
	localparam logic [15:0] TILE_ONE = 16'd256;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_DRAW  = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CMP,
		F_PUSH
	} fst_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FLUSH,
		B_ROT,
		B_MUL,
		B_SUM,
		B_OFF,
		B_EMIT
	} bst_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic [15:0]        angle;
		logic [31:0]        color;
		logic               textured;
		logic [15:0]        texture_id;
		logic [15:0]        tile_scale;
	} cmd_in_t;

	// work record passed from front to back through the queue
	typedef struct packed {
		logic               flush_en;
		logic [INDEX_W-1:0] flush_cnt;
		logic               draw_en;
		logic [SLOT_W-1:0]  slot;
		logic [15:0]        tiling;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic [15:0]        angle;
		logic [31:0]        color;
	} work_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [31:0]        vert_color;
		logic               tex_u;
		logic               tex_v;
		logic [SLOT_W-1:0]  slot;
		logic [15:0]        vert_tiling;
		logic [INDEX_W-1:0] index_count;
		logic               last;
	} res_t;

	// arc tangent of 2^-i in 1/65536 turn
	function automatic logic signed [Z_W-1:0] arc_of(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			4'd0:    a = 16'sd8192;
			4'd1:    a = 16'sd4836;
			4'd2:    a = 16'sd2555;
			4'd3:    a = 16'sd1297;
			4'd4:    a = 16'sd651;
			4'd5:    a = 16'sd326;
			4'd6:    a = 16'sd163;
			4'd7:    a = 16'sd81;
			4'd8:    a = 16'sd41;
			4'd9:    a = 16'sd20;
			4'd10:   a = 16'sd10;
			4'd11:   a = 16'sd5;
			4'd12:   a = 16'sd3;
			4'd13:   a = 16'sd1;
			4'd14:   a = 16'sd1;
			default: a = 16'sd0;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/sqvb_cmd_if.sv]
// Command channel interface: valid/ready plus the command fields.
// Depends on sqvb_pkg.
interface sqvb_cmd_if;
	import sqvb_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] size_x;
	logic signed [31:0] size_y;
	logic [15:0]        angle;
	logic [31:0]        color;
	logic               textured;
	logic [15:0]        texture_id;
	logic [15:0]        tile_scale;

	modport source (output valid, opcode, pos_x, pos_y, pos_z, size_x, size_y, angle,
		color, textured, texture_id, tile_scale, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, pos_z, size_x, size_y, angle,
		color, textured, texture_id, tile_scale, output ready);
endinterface

[hw/rtl/sqvb_res_if.sv]
// Result channel interface: valid/ready plus vertex and flush record fields.
// Depends on sqvb_pkg.
interface sqvb_res_if;
	import sqvb_pkg::*;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic signed [31:0] vert_z;
	logic [31:0]        vert_color;
	logic               tex_u;
	logic               tex_v;
	logic [SLOT_W-1:0]  slot;
	logic [15:0]        vert_tiling;
	logic [INDEX_W-1:0] index_count;
	logic               last;

	modport source (output valid, kind, vert_x, vert_y, vert_z, vert_color, tex_u, tex_v,
		slot, vert_tiling, index_count, last, input ready);
	modport sink (input valid, kind, vert_x, vert_y, vert_z, vert_color, tex_u, tex_v,
		slot, vert_tiling, index_count, last, output ready);
endinterface

[hw/rtl/sqvb_front.sv]
// Front end: accepts commands, keeps batch counters and the texture slot table,
// and pushes one work record per emitting command. Depends on sqvb_pkg, sqvb_cmd_if.
module sqvb_front
	import sqvb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sqvb_cmd_if.sink    cmd,
	output logic        push_valid,
	output work_t       push_rec,
	input  logic        push_ready
);

	fst_t              st_q, st_d;
	cmd_in_t           hold_q;
	logic [15:0]       slot_ids_q [1:SLOT_TABLE_SIZE-1];
	logic [USED_W-1:0] used_q, used_d;
	logic [QCNT_W-1:0] quads_q, quads_d;
	logic [SLOT_TABLE_SIZE-1:1] match_q;
	logic              pre_full_q;

	logic              pre_full;
	logic [USED_W-1:0] cmp_used;
	logic              found;
	logic [SIDX_W-1:0] hit_idx;
	logic [USED_W-1:0] eff_used;
	logic              miss;
	logic              flush;
	logic [USED_W-1:0] base_used;
	logic [SIDX_W-1:0] ins_at;
	logic              ins_en;
	logic [INDEX_W-1:0] cnt6;

	assign pre_full = (hold_q.opcode == OP_DRAW) && (quads_q >= QCNT_W'(BATCH_QUAD_CAP));
	assign cmp_used = pre_full ? USED_W'(1) : used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= F_IDLE;
			used_q  <= USED_W'(1);
			quads_q <= '0;
		end else begin
			st_q    <= st_d;
			used_q  <= used_d;
			quads_q <= quads_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			hold_q.opcode        <= cmd.opcode;
			hold_q.pos_x         <= cmd.pos_x;
			hold_q.pos_y         <= cmd.pos_y;
			hold_q.pos_z         <= cmd.pos_z;
			hold_q.size_x        <= cmd.size_x;
			hold_q.size_y        <= cmd.size_y;
			hold_q.angle         <= cmd.angle;
			hold_q.color         <= cmd.color;
			hold_q.textured      <= cmd.textured;
			hold_q.texture_id    <= cmd.texture_id;
			hold_q.tile_scale    <= cmd.tile_scale;
		end
		if (st_q == F_CMP) begin
			pre_full_q <= pre_full;
			for (int i = 1; i < SLOT_TABLE_SIZE; i++)
				match_q[i] <= (slot_ids_q[i] == hold_q.texture_id) &&
					(USED_W'(i) < cmp_used);
		end
		if (ins_en)
			slot_ids_q[ins_at] <= hold_q.texture_id;
	end

	always_comb begin
		found   = |match_q;
		hit_idx = '0;
		for (int i = SLOT_TABLE_SIZE - 1; i >= 1; i--)
			if (match_q[i])
				hit_idx = SIDX_W'(i);
	end

	assign eff_used  = pre_full_q ? USED_W'(1) : used_q;
	assign miss      = hold_q.textured && !found;
	assign flush     = pre_full_q || (miss && (eff_used >= USED_W'(SLOT_TABLE_SIZE)));
	assign base_used = flush ? USED_W'(1) : used_q;
	assign ins_at    = base_used[SIDX_W-1:0];
	assign cnt6      = INDEX_W'(quads_q) * INDEX_W'(6);

	always_comb begin
		st_d      = st_q;
		used_d    = used_q;
		quads_d   = quads_q;
		ins_en    = 1'b0;
		cmd.ready = 1'b0;
		push_valid = 1'b0;

		push_rec.flush_en  = 1'b0;
		push_rec.flush_cnt = cnt6;
		push_rec.draw_en   = 1'b0;
		push_rec.slot      = '0;
		push_rec.tiling    = TILE_ONE;
		push_rec.pos_x     = hold_q.pos_x;
		push_rec.pos_y     = hold_q.pos_y;
		push_rec.pos_z     = hold_q.pos_z;
		push_rec.size_x    = hold_q.size_x;
		push_rec.size_y    = hold_q.size_y;
		push_rec.angle     = hold_q.angle;
		push_rec.color     = hold_q.color;

		case (st_q)
			F_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid)
					st_d = F_CMP;
			end
			F_CMP: begin
				st_d = F_PUSH;
			end
			F_PUSH: begin
				case (hold_q.opcode)
					OP_BEGIN: begin
						used_d  = USED_W'(1);
						quads_d = '0;
						st_d    = F_IDLE;
					end
					OP_END: begin
						push_valid        = 1'b1;
						push_rec.flush_en = 1'b1;
						if (push_ready)
							st_d = F_IDLE;
					end
					OP_DRAW: begin
						push_valid        = 1'b1;
						push_rec.flush_en = flush;
						push_rec.draw_en  = 1'b1;
						if (hold_q.textured) begin
							push_rec.tiling = hold_q.tile_scale;
							push_rec.slot   = SLOT_W'(found ? hit_idx : ins_at);
						end
						if (push_ready) begin
							ins_en  = miss;
							used_d  = base_used + USED_W'(miss);
							quads_d = (flush ? QCNT_W'(0) : quads_q) + QCNT_W'(1);
							st_d    = F_IDLE;
						end
					end
					default: begin
						st_d = F_IDLE;
					end
				endcase
			end
			default: begin
				st_d = F_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/sqvb_queue.sv]
// Two-entry queue of work records between front and back.
// Depends on sqvb_pkg.
module sqvb_queue
	import sqvb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  work_t push_rec,
	output logic  push_ready,
	output logic  pop_valid,
	output work_t pop_rec,
	input  logic  pop_ready,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = $clog2(QDEPTH);

	work_t                 mem_q [QDEPTH];
	logic [PTR_W-1:0]      wr_q, rd_q;
	logic [$clog2(QDEPTH+1)-1:0] cnt_q;
	logic                  do_push, do_pop;

	assign full       = (cnt_q == ($clog2(QDEPTH+1))'(QDEPTH));
	assign empty      = (cnt_q == '0);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_rec    = mem_q[rd_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop_ready && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			cnt_q <= cnt_q + ($clog2(QDEPTH+1))'(do_push) - ($clog2(QDEPTH+1))'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_rec;
	end

endmodule

[hw/rtl/sqvb_back.sv]
// Back end: CORDIC sine/cosine, shared multiplier, corner offsets and the
// registered result stage. Depends on sqvb_pkg, sqvb_res_if.
module sqvb_back
	import sqvb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	input  work_t     pop_rec,
	output logic      pop_ready,
	sqvb_res_if.source res
);

	bst_t               st_q, st_d;
	work_t              w_q;
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         k_q;
	logic signed [CS_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [PROD_W-1:0] prod_q [4];
	logic signed [SUM_W-1:0]  p_q, m_q, qs_q, r_q;
	logic [31:0]        offx_q [4];
	logic [31:0]        offy_q [4];
	logic               out_v_q;
	res_t               out_q;

	logic               load;
	logic signed [CS_W-1:0] co, si, dx, dy;
	logic signed [CS_W-1:0] mul_a;
	logic signed [31:0]     mul_b;
	logic signed [SUM_W-1:0] vx [4];
	logic signed [SUM_W-1:0] vy [4];

	assign load = !out_v_q || res.ready;

	always_comb begin
		case (w_q.angle[15:14])
			2'd0:    begin co = x_q;  si = y_q;  end
			2'd1:    begin co = -y_q; si = x_q;  end
			2'd2:    begin co = -x_q; si = -y_q; end
			default: begin co = y_q;  si = -x_q; end
		endcase
		case (k_q)
			2'd0:    begin mul_a = co; mul_b = w_q.size_x; end
			2'd1:    begin mul_a = si; mul_b = w_q.size_y; end
			2'd2:    begin mul_a = si; mul_b = w_q.size_x; end
			default: begin mul_a = co; mul_b = w_q.size_y; end
		endcase
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	// corners (-,-) (+,-) (+,+) (-,+): x uses -M P M -P, y uses -Q R Q -R
	assign vx[0] = -m_q;
	assign vx[1] = p_q;
	assign vx[2] = m_q;
	assign vx[3] = -p_q;
	assign vy[0] = -qs_q;
	assign vy[1] = r_q;
	assign vy[2] = qs_q;
	assign vy[3] = -r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load)
				out_v_q <= (st_q == B_FLUSH) || (st_q == B_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (pop_valid) begin
					w_q    <= pop_rec;
					x_q    <= CS_W'(CORDIC_GAIN);
					y_q    <= '0;
					z_q    <= Z_W'({2'b00, pop_rec.angle[13:0]});
					step_q <= '0;
					k_q    <= '0;
				end
			end
			B_ROT: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - arc_of(step_q);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + arc_of(step_q);
				end
				step_q <= step_q + STEP_W'(1);
			end
			B_MUL: begin
				prod_q[k_q] <= PROD_W'(mul_a) * PROD_W'(mul_b);
				k_q <= k_q + 2'd1;
			end
			B_SUM: begin
				p_q  <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]);
				m_q  <= SUM_W'(prod_q[0]) - SUM_W'(prod_q[1]);
				qs_q <= SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
				r_q  <= SUM_W'(prod_q[2]) - SUM_W'(prod_q[3]);
			end
			B_OFF: begin
				for (int c = 0; c < 4; c++) begin
					offx_q[c] <= 32'((OFS_W'(vx[c]) + OFS_W'(ROUND_HALF)) >>> 17);
					offy_q[c] <= 32'((OFS_W'(vy[c]) + OFS_W'(ROUND_HALF)) >>> 17);
				end
			end
			B_EMIT: begin
				if (load)
					k_q <= k_q + 2'd1;
			end
			default: begin
			end
		endcase

		if (load && st_q == B_FLUSH) begin
			out_q             <= '0;
			out_q.kind        <= 1'b1;
			out_q.index_count <= w_q.flush_cnt;
			out_q.last        <= !w_q.draw_en;
		end else if (load && st_q == B_EMIT) begin
			out_q.kind        <= 1'b0;
			out_q.vert_x      <= w_q.pos_x + offx_q[k_q];
			out_q.vert_y      <= w_q.pos_y + offy_q[k_q];
			out_q.vert_z      <= w_q.pos_z;
			out_q.vert_color  <= w_q.color;
			out_q.tex_u       <= k_q[0] ^ k_q[1];
			out_q.tex_v       <= k_q[1];
			out_q.slot        <= w_q.slot;
			out_q.vert_tiling <= w_q.tiling;
			out_q.index_count <= '0;
			out_q.last        <= (k_q == 2'd3);
		end
	end

	always_comb begin
		st_d      = st_q;
		pop_ready = 1'b0;
		case (st_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid)
					st_d = pop_rec.flush_en ? B_FLUSH : B_ROT;
			end
			B_FLUSH: begin
				if (load)
					st_d = w_q.draw_en ? B_ROT : B_IDLE;
			end
			B_ROT: begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1))
					st_d = B_MUL;
			end
			B_MUL: begin
				if (k_q == 2'd3)
					st_d = B_SUM;
			end
			B_SUM: st_d = B_OFF;
			B_OFF: st_d = B_EMIT;
			B_EMIT: begin
				if (load && k_q == 2'd3)
					st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	assign res.valid       = out_v_q;
	assign res.kind        = out_q.kind;
	assign res.vert_x      = out_q.vert_x;
	assign res.vert_y      = out_q.vert_y;
	assign res.vert_z      = out_q.vert_z;
	assign res.vert_color  = out_q.vert_color;
	assign res.tex_u       = out_q.tex_u;
	assign res.tex_v       = out_q.tex_v;
	assign res.slot        = out_q.slot;
	assign res.vert_tiling = out_q.vert_tiling;
	assign res.index_count = out_q.index_count;
	assign res.last        = out_q.last;

endmodule

[hw/rtl/sprite_quad_vertex_batcher_core.sv]
// Sprite quad vertex batcher, top level.
// cmd (sink): begin scene, draw quad, end scene; one beat per command.
// vtx (source): vertex and flush records; last marks the final beat of a command.
// The front takes one command at a time, keeps the quad count and texture
// slot table, and queues a work record (two entries) for the back.
// A draw occupies the back for 15 CORDIC iterations, four products on one
// shared 19x32 multiplier, the sum and offset steps and four vertex beats;
// a flush ahead of it adds one beat. End scene uses only the flush state.
// With an idle back, an accepted command passes the front's compare and push
// states and the queue, and the back registers its first beat from the flush
// or emit state. Begin scene and unknown opcodes produce no beats.
// Reset clears the batch: quad count zero, one slot in use (white).
// A stalled vtx holds its beat in the output register; the back then stops,
// the queue fills and cmd.ready drops once the front cannot push.
// Depends on sqvb_pkg, sqvb_cmd_if, sqvb_res_if, sqvb_front, sqvb_queue, sqvb_back.
module sprite_quad_vertex_batcher_core
	import sqvb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sqvb_cmd_if.sink   cmd,
	sqvb_res_if.source vtx
);

	logic  push_valid, push_ready, pop_valid, pop_ready, q_full, q_empty;
	work_t push_rec, pop_rec;

	sqvb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.push_ready (push_ready)
	);

	sqvb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_rec    (pop_rec),
		.pop_ready  (pop_ready),
		.full       (q_full),
		.empty      (q_empty)
	);

	sqvb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop_ready (pop_ready),
		.res       (vtx)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && vtx.kind |-> vtx.vert_x == 0 && vtx.slot == 0 && vtx.tex_u == 0)
		else $error("flush beat carries vertex data");

	a_vertex_count: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && !vtx.kind |-> vtx.index_count == 0)
		else $error("vertex beat carries an index count");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for sprite_quad_vertex_batcher_core: drives commands, predicts
// vertex and flush beats in a scoreboard class and compares every accepted beat.
// Depends on sqvb_pkg, sqvb_cmd_if, sqvb_res_if and the core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sqvb_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_LEN = 600;

	class vertex_scoreboard;
		res_t pending[$];
		logic [15:0] ids[SLOT_TABLE_SIZE];
		int unsigned used;
		int unsigned quads;
		int errors;
		int unsigned arcs[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1};

		function new();
			used = 1;
			quads = 0;
			errors = 0;
			foreach (ids[i]) ids[i] = '0;
		endfunction

		function void push_flush(logic is_last);
			res_t r;
			r = '0;
			r.kind = 1'b1;
			r.index_count = INDEX_W'(quads * 6);
			r.last = is_last;
			pending.push_back(r);
		endfunction

		function void sin_cos(logic [15:0] ang, output longint co, output longint si);
			longint x, y, z, dx, dy;
			x = CORDIC_GAIN;
			y = 0;
			z = longint'(ang[13:0]);
			for (int i = 0; i < 15; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= arcs[i];
				end else begin
					x += dx; y -= dy; z += arcs[i];
				end
			end
			case (ang[15:14])
				2'd0: begin co = x; si = y; end
				2'd1: begin co = -y; si = x; end
				2'd2: begin co = -x; si = -y; end
				default: begin co = y; si = -x; end
			endcase
		endfunction

		// note one accepted command and queue the beats it causes
		function void note_command(cmd_in_t c);
			int unsigned slot_no;
			logic [15:0] tile;
			bit found;
			longint co, si, nx, ny, ex, ey;
			res_t r;
			case (c.opcode)
				OP_BEGIN: begin
					quads = 0; used = 1;
				end
				OP_END: push_flush(1'b1);
				OP_DRAW: begin
					if (quads >= BATCH_QUAD_CAP) begin
						push_flush(1'b0);
						quads = 0; used = 1;
					end
					slot_no = 0;
					tile = TILE_ONE;
					if (c.textured) begin
						tile = c.tile_scale;
						found = 0;
						for (int i = 1; i < used; i++)
							if (!found && ids[i] == c.texture_id) begin
								slot_no = i; found = 1;
							end
						if (!found) begin
							if (used >= SLOT_TABLE_SIZE) begin
								push_flush(1'b0);
								quads = 0; used = 1;
							end
							ids[used] = c.texture_id;
							slot_no = used;
							used++;
						end
					end
					sin_cos(c.angle, co, si);
					for (int k = 0; k < 4; k++) begin
						ex = (k == 0 || k == 3) ? -1 : 1;
						ey = (k < 2) ? -1 : 1;
						nx = ex * co * longint'(c.size_x) - ey * si * longint'(c.size_y);
						ny = ex * si * longint'(c.size_x) + ey * co * longint'(c.size_y);
						r = '0;
						r.vert_x = 32'(longint'(c.pos_x) + ((nx + ROUND_HALF) >>> 17));
						r.vert_y = 32'(longint'(c.pos_y) + ((ny + ROUND_HALF) >>> 17));
						r.vert_z = c.pos_z;
						r.vert_color = c.color;
						r.tex_u = (k == 1 || k == 2);
						r.tex_v = (k >= 2);
						r.slot = SLOT_W'(slot_no);
						r.vert_tiling = tile;
						r.last = (k == 3);
						pending.push_back(r);
					end
					quads++;
				end
				default: ;
			endcase
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_beat(res_t g);
			res_t w;
			if (pending.size() == 0) begin
				report("unexpected beat kind", g.kind, 0);
				return;
			end
			w = pending.pop_front();
			if (g.kind !== w.kind) report("kind", g.kind, w.kind);
			if (g.vert_x !== w.vert_x) report("vert_x", g.vert_x, w.vert_x);
			if (g.vert_y !== w.vert_y) report("vert_y", g.vert_y, w.vert_y);
			if (g.vert_z !== w.vert_z) report("vert_z", g.vert_z, w.vert_z);
			if (g.vert_color !== w.vert_color) report("vert_color", g.vert_color, w.vert_color);
			if (g.tex_u !== w.tex_u) report("tex_u", g.tex_u, w.tex_u);
			if (g.tex_v !== w.tex_v) report("tex_v", g.tex_v, w.tex_v);
			if (g.slot !== w.slot) report("slot", g.slot, w.slot);
			if (g.vert_tiling !== w.vert_tiling) report("vert_tiling", g.vert_tiling,
				w.vert_tiling);
			if (g.index_count !== w.index_count) report("index_count", g.index_count,
				w.index_count);
			if (g.last !== w.last) report("last", g.last, w.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	sqvb_cmd_if cmd ();
	sqvb_res_if vtx ();

	sprite_quad_vertex_batcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.vtx(vtx.source)
	);

	vertex_scoreboard sb;
	int snd_idle_pct;
	int rcv_stall_pct;
	bit hold_req;
	int hold_cnt;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.opcode = OP_BEGIN;
		cmd.pos_x = '0; cmd.pos_y = '0; cmd.pos_z = '0;
		cmd.size_x = '0; cmd.size_y = '0;
		cmd.angle = '0; cmd.color = '0;
		cmd.textured = 1'b0; cmd.texture_id = '0; cmd.tile_scale = '0;
		vtx.ready = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			vtx.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = HOLD_LEN;
			vtx.ready <= 1'b0;
		end else
			vtx.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		res_t g;
		if (arst_n && vtx.valid && vtx.ready) begin
			g.kind = vtx.kind; g.vert_x = vtx.vert_x; g.vert_y = vtx.vert_y;
			g.vert_z = vtx.vert_z; g.vert_color = vtx.vert_color;
			g.tex_u = vtx.tex_u; g.tex_v = vtx.tex_v; g.slot = vtx.slot;
			g.vert_tiling = vtx.vert_tiling; g.index_count = vtx.index_count;
			g.last = vtx.last;
			sb.check_beat(g);
		end
		if (arst_n && !(vtx.valid && vtx.ready) && !(cmd.valid && cmd.ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(cmd_in_t c);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= c.opcode; cmd.pos_x <= c.pos_x; cmd.pos_y <= c.pos_y;
		cmd.pos_z <= c.pos_z; cmd.size_x <= c.size_x; cmd.size_y <= c.size_y;
		cmd.angle <= c.angle; cmd.color <= c.color; cmd.textured <= c.textured;
		cmd.texture_id <= c.texture_id; cmd.tile_scale <= c.tile_scale;
		do @(posedge clk); while (!cmd.ready);
		sb.note_command(c);
	endtask

	task automatic go_idle();
		cmd.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cmd_in_t quad(logic [15:0] ang, logic tex, logic [15:0] id,
		logic [15:0] tile);
		cmd_in_t c;
		c.opcode = OP_DRAW;
		c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom;
		// sizes mostly within -2^25 to 2^25-1 units, sometimes any value
		if ($urandom_range(3) == 0) begin
			c.size_x = $urandom; c.size_y = $urandom;
		end else begin
			c.size_x = $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
			c.size_y = $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
		end
		c.angle = ang; c.color = $urandom;
		c.textured = tex; c.texture_id = id; c.tile_scale = tile;
		return c;
	endfunction

	function automatic cmd_in_t simple(logic [1:0] op);
		cmd_in_t c;
		c = quad(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
		c.opcode = op;
		return c;
	endfunction

	function automatic cmd_in_t random_cmd();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) return simple(OP_BEGIN);
		if (pick < 12) return simple(OP_END);
		if (pick < 15) return simple(OP_NONE);
		return quad(16'($urandom), 1'($urandom_range(1)), 16'($urandom_range(40) * 1637),
			16'($urandom));
	endfunction

	task automatic wait_drained();
		go_idle();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		cmd_in_t c;
		sb = new();
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_req = 0;
		hold_cnt = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: end on empty batch, extremes, quadrants, slots, repeats
		send(simple(OP_END));
		c = quad(16'h0000, 1'b0, 16'h0, 16'h0);
		c.pos_x = 32'h7FFFFFFF; c.pos_y = 32'h80000000;
		c.size_x = 32'h7FFFFFFF; c.size_y = 32'h80000000;
		send(c);
		c = quad(16'h4000, 1'b0, 16'hFFFF, 16'hFFFF);
		c.pos_x = 32'h80000000; c.pos_y = 32'h7FFFFFFF;
		c.size_x = 32'h80000000; c.size_y = 32'h7FFFFFFF;
		c.pos_z = 32'hFFFFFFFF; c.color = 32'hFFFFFFFF;
		send(c);
		send(quad(16'h8000, 1'b1, 16'h0000, 16'h0000));
		send(quad(16'hC000, 1'b1, 16'hFFFF, 16'hFFFF));
		send(quad(16'hFFFF, 1'b1, 16'h0000, 16'h0100));
		send(quad(16'h3FFF, 1'b1, 16'hFFFF, 16'h8001));
		send(simple(OP_END));
		send(simple(OP_END));
		send(quad(16'h2000, 1'b0, 16'h0, 16'h0));
		send(simple(OP_NONE));
		send(simple(OP_END));
		send(simple(OP_BEGIN));
		send(simple(OP_END));
		send(quad(16'h1234, 1'b1, 16'h00AA, 16'h0200));

		// full slot table: 31 fresh ids fill it, the next one forces a flush
		send(simple(OP_BEGIN));
		for (int i = 0; i < 33; i++)
			send(quad(16'($urandom), 1'b1, 16'(16'h5000 + i), 16'($urandom)));
		send(simple(OP_END));

		for (int ph = 0; ph < 4; ph++) begin
			snd_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 83) : 0;
			rcv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 83) : 0;
			if (ph == 0) hold_req = 1;
			for (int i = 0; i < 42; i++)
				send(random_cmd());
			// pause until every beat is out
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sqvb_pkg.sv
hw/rtl/sqvb_cmd_if.sv
hw/rtl/sqvb_res_if.sv
hw/rtl/sqvb_front.sv
hw/rtl/sqvb_queue.sv
hw/rtl/sqvb_back.sv
hw/rtl/sprite_quad_vertex_batcher_core.sv
tb/sv/testbench.sv
